// File: hdl/fsim_pkg.sv
// ----------------------------------------------------------------------------
// Fisheye sphere-to-image map: shared package
// Register layout, fixed-point constants, arctangent table and clamp helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fsim_pkg;

	localparam int NITER     = 24;
	localparam int ANG_W     = 29;
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 31;

	localparam logic signed [ANG_W-1:0] ANG_PI      = 29'sd52707179;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 29'sd26353589;
	localparam logic signed [33:0]      CORDIC_K    = 34'sd652032874;
	localparam logic signed [18:0]      ONE_Q14     = 19'sd16384;
	localparam logic signed [32:0]      SCALE_FAR   = 33'sd16384000;

	localparam logic signed [ANG_W-1:0] ATAN_TAB [NITER] = '{
		29'sd13176795, 29'sd7778716, 29'sd4110060, 29'sd2086331, 29'sd1047214,
		29'sd524117, 29'sd262123, 29'sd131069, 29'sd65536, 29'sd32768,
		29'sd16384, 29'sd8192, 29'sd4096, 29'sd2048, 29'sd1024, 29'sd512,
		29'sd256, 29'sd128, 29'sd64, 29'sd32, 29'sd16, 29'sd8, 29'sd4, 29'sd2
	};

	typedef enum logic [2:0] {
		REG_PPR      = 3'd0,
		REG_POLY     = 3'd1,
		REG_INV_NORM = 3'd2,
		REG_LIMIT    = 3'd3,
		REG_SHIFT    = 3'd4,
		REG_OFFSET   = 3'd5,
		REG_INV_SIZE = 3'd6,
		REG_CROP     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] ppr;
		logic [47:0] poly;
		logic [23:0] inv_norm;
		logic [19:0] limit;
		logic [31:0] shift;
		logic [31:0] offset;
		logic [47:0] inv_size;
		logic [48:0] crop;
	} cfg_t;

	function automatic logic signed [32:0] clamp_scale(input logic signed [63:0] v);
		if (v > 64'sd2147483648)
			return 33'sd2147483648;
		else if (v < -64'sd2147483648)
			return -33'sd2147483648;
		else
			return v[32:0];
	endfunction

	function automatic logic signed [39:0] clamp_pos(input logic signed [64:0] v);
		if (v > 65'sd274877906944)
			return 40'sd274877906944;
		else if (v < -65'sd274877906944)
			return -40'sd274877906944;
		else
			return v[39:0];
	endfunction

	function automatic logic signed [19:0] clamp_norm(input logic signed [65:0] v);
		if (v > 66'sd524287)
			return 20'sd524287;
		else if (v < -66'sd524288)
			return -20'sd524288;
		else
			return v[19:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/fsim_regs.sv
// ----------------------------------------------------------------------------
// Fisheye sphere-to-image map: configuration registers
// APB-style register file holding the eight lens and frame registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fsim_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output fsim_pkg::cfg_t cfg
);
	import fsim_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[5:3]);
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ppr      <= 24'd4096;
			cfg_q.poly     <= '0;
			cfg_q.inv_norm <= 24'd16384;
			cfg_q.limit    <= 20'd1024000;
			cfg_q.shift    <= '0;
			cfg_q.offset   <= '0;
			cfg_q.inv_size <= '0;
			cfg_q.crop     <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_PPR:      cfg_q.ppr      <= pwdata[23:0];
				REG_POLY:     cfg_q.poly     <= pwdata[47:0];
				REG_INV_NORM: cfg_q.inv_norm <= pwdata[23:0];
				REG_LIMIT:    cfg_q.limit    <= pwdata[19:0];
				REG_SHIFT:    cfg_q.shift    <= pwdata[31:0];
				REG_OFFSET:   cfg_q.offset   <= pwdata[31:0];
				REG_INV_SIZE: cfg_q.inv_size <= pwdata[47:0];
				REG_CROP:     cfg_q.crop     <= pwdata[48:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PPR:      prdata = {40'd0, cfg_q.ppr};
			REG_POLY:     prdata = {16'd0, cfg_q.poly};
			REG_INV_NORM: prdata = {40'd0, cfg_q.inv_norm};
			REG_LIMIT:    prdata = {44'd0, cfg_q.limit};
			REG_SHIFT:    prdata = {32'd0, cfg_q.shift};
			REG_OFFSET:   prdata = {32'd0, cfg_q.offset};
			REG_INV_SIZE: prdata = {16'd0, cfg_q.inv_size};
			REG_CROP:     prdata = {15'd0, cfg_q.crop};
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/fsim_sincos.sv
// ----------------------------------------------------------------------------
// Fisheye sphere-to-image map: sine and cosine pipeline
// Two rotation CORDIC lanes, one stage per iteration, for longitude and latitude.
// ----------------------------------------------------------------------------
`default_nettype none

module fsim_sincos (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic signed [15:0] lon,
	input  logic signed [15:0] lat,
	output logic               out_valid,
	output logic signed [31:0] cos_lon,
	output logic signed [31:0] sin_lon,
	output logic signed [31:0] cos_lat,
	output logic signed [31:0] sin_lat
);
	import fsim_pkg::*;

	logic [NITER+1:0]        v_s;
	logic signed [ANG_W-1:0] ang_in [2];
	logic signed [33:0]      x_s   [2][NITER+1];
	logic signed [33:0]      y_s   [2][NITER+1];
	logic signed [ANG_W-1:0] z_s   [2][NITER+1];
	logic                    neg_s [2][NITER+1];
	logic signed [31:0]      c_q   [2];
	logic signed [31:0]      s_q   [2];

	assign ang_in[0] = {{2{lon[15]}}, lon, 11'b0};
	assign ang_in[1] = {{2{lat[15]}}, lat, 11'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (adv)
			v_s <= {v_s[NITER:0], in_valid};
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [ANG_W-1:0] zr;
		logic                    nr;

		always_comb begin
			zr = ang_in[l];
			nr = 1'b0;
			if (ang_in[l] > ANG_HALF_PI) begin
				zr = ang_in[l] - ANG_PI;
				nr = 1'b1;
			end else if (ang_in[l] < -ANG_HALF_PI) begin
				zr = ang_in[l] + ANG_PI;
				nr = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[l][0]   <= CORDIC_K;
				y_s[l][0]   <= '0;
				z_s[l][0]   <= zr;
				neg_s[l][0] <= nr;
			end
		end

		for (genvar i = 0; i < NITER; i++) begin : g_iter
			always_ff @(posedge clk) begin
				if (adv) begin
					neg_s[l][i+1] <= neg_s[l][i];
					if (!z_s[l][i][ANG_W-1]) begin
						x_s[l][i+1] <= x_s[l][i] - (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] + (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] - ATAN_TAB[i];
					end else begin
						x_s[l][i+1] <= x_s[l][i] + (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] - (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] + ATAN_TAB[i];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				c_q[l] <= 32'(neg_s[l][NITER] ? -x_s[l][NITER] : x_s[l][NITER]);
				s_q[l] <= 32'(neg_s[l][NITER] ? -y_s[l][NITER] : y_s[l][NITER]);
			end
		end
	end

	assign out_valid = v_s[NITER+1];
	assign cos_lon   = c_q[0];
	assign sin_lon   = s_q[0];
	assign cos_lat   = c_q[1];
	assign sin_lat   = s_q[1];

endmodule

`default_nettype wire

// File: hdl/fsim_vector.sv
// ----------------------------------------------------------------------------
// Fisheye sphere-to-image map: view vector pipeline
// Forms the view vector, its radial length by a bitwise square root, the
// off-axis angle by a vectoring CORDIC and the unit direction by division.
// ----------------------------------------------------------------------------
`default_nettype none

module fsim_vector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic signed [31:0] cos_lon,
	input  logic signed [31:0] sin_lon,
	input  logic signed [31:0] cos_lat,
	input  logic signed [31:0] sin_lat,
	output logic               out_valid,
	output logic [25:0]        theta,
	output logic signed [31:0] ux,
	output logic signed [31:0] uy,
	output logic               on_axis
);
	import fsim_pkg::*;

	localparam int VLAT = 2 + SQ_STEPS + 1 + DIV_STEPS + 1 + 1;

	logic [VLAT-1:0]    v_s;
	logic signed [63:0] m0_s1, m1_s1;
	logic signed [31:0] v1_s1;
	logic signed [32:0] v0_s2, v1_s2, s_s2;

	logic [63:0]        rem_s [SQ_STEPS+1];
	logic [63:0]        res_s [SQ_STEPS+1];
	logic signed [32:0] qv0_s [SQ_STEPS+1];
	logic signed [32:0] qv1_s [SQ_STEPS+1];
	logic signed [32:0] qs_s  [SQ_STEPS+1];

	logic signed [35:0]      ax_s   [DIV_STEPS+1];
	logic signed [35:0]      ay_s   [DIV_STEPS+1];
	logic signed [ANG_W-1:0] az_s   [DIV_STEPS+1];
	logic [31:0]             r_s    [DIV_STEPS+1];
	logic [31:0]             mg0_s  [DIV_STEPS+1];
	logic [31:0]             mg1_s  [DIV_STEPS+1];
	logic [31:0]             dr0_s  [DIV_STEPS+1];
	logic [31:0]             dr1_s  [DIV_STEPS+1];
	logic [30:0]             q0_s   [DIV_STEPS+1];
	logic [30:0]             q1_s   [DIV_STEPS+1];
	logic                    n0_s   [DIV_STEPS+1];
	logic                    n1_s   [DIV_STEPS+1];
	logic                    zr_s   [DIV_STEPS+1];

	logic signed [33:0] p0, p1;
	logic [31:0]        r_fin;
	logic signed [32:0] s_fin;
	logic signed [32:0] ux_w, uy_w;

	logic [25:0]        theta_q;
	logic signed [31:0] ux_q, uy_q;
	logic               zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (adv)
			v_s <= {v_s[VLAT-2:0], in_valid};
	end

	assign p0 = 34'(m0_s1 >>> 30);
	assign p1 = 34'(m1_s1 >>> 30);

	always_ff @(posedge clk) begin
		if (adv) begin
			m0_s1 <= cos_lat * sin_lon;
			m1_s1 <= cos_lat * cos_lon;
			v1_s1 <= sin_lat;
			v0_s2 <= 33'(-p0);
			v1_s2 <= 33'(v1_s1);
			s_s2  <= 33'(p1);
			rem_s[0] <= 64'(v0_s2 * v0_s2) + 64'(v1_s2 * v1_s2);
			res_s[0] <= '0;
			qv0_s[0] <= v0_s2;
			qv1_s[0] <= v1_s2;
			qs_s[0]  <= s_s2;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;

		assign trial = res_s[k] + BIT;

		always_ff @(posedge clk) begin
			if (adv) begin
				qv0_s[k+1] <= qv0_s[k];
				qv1_s[k+1] <= qv1_s[k];
				qs_s[k+1]  <= qs_s[k];
				if (rem_s[k] >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign r_fin = res_s[SQ_STEPS][31:0];
	assign s_fin = qs_s[SQ_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (s_fin[32]) begin
				ax_s[0] <= 36'({1'b0, r_fin});
				ay_s[0] <= 36'(-s_fin);
				az_s[0] <= ANG_HALF_PI;
			end else begin
				ax_s[0] <= 36'(s_fin);
				ay_s[0] <= 36'({1'b0, r_fin});
				az_s[0] <= '0;
			end
			r_s[0]   <= r_fin;
			mg0_s[0] <= 32'(qv0_s[SQ_STEPS][32] ? -qv0_s[SQ_STEPS] : qv0_s[SQ_STEPS]);
			mg1_s[0] <= 32'(qv1_s[SQ_STEPS][32] ? -qv1_s[SQ_STEPS] : qv1_s[SQ_STEPS]);
			n0_s[0]  <= qv0_s[SQ_STEPS][32];
			n1_s[0]  <= qv1_s[SQ_STEPS][32];
			zr_s[0]  <= (r_fin == 32'd0);
			dr0_s[0] <= '0;
			dr1_s[0] <= '0;
			q0_s[0]  <= '0;
			q1_s[0]  <= '0;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [32:0] rin0, rin1;
		logic        b0, b1;

		if (j == 0) begin : g_first
			assign rin0 = {1'b0, mg0_s[j]};
			assign rin1 = {1'b0, mg1_s[j]};
		end else begin : g_next
			assign rin0 = {dr0_s[j], 1'b0};
			assign rin1 = {dr1_s[j], 1'b0};
		end

		assign b0 = rin0 >= {1'b0, r_s[j]};
		assign b1 = rin1 >= {1'b0, r_s[j]};

		always_ff @(posedge clk) begin
			if (adv) begin
				r_s[j+1]   <= r_s[j];
				mg0_s[j+1] <= mg0_s[j];
				mg1_s[j+1] <= mg1_s[j];
				n0_s[j+1]  <= n0_s[j];
				n1_s[j+1]  <= n1_s[j];
				zr_s[j+1]  <= zr_s[j];
				dr0_s[j+1] <= 32'(b0 ? rin0 - {1'b0, r_s[j]} : rin0);
				dr1_s[j+1] <= 32'(b1 ? rin1 - {1'b0, r_s[j]} : rin1);
				q0_s[j+1]  <= {q0_s[j][29:0], b0};
				q1_s[j+1]  <= {q1_s[j][29:0], b1};
			end
		end

		if (j < NITER) begin : g_atan
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!ay_s[j][35]) begin
						ax_s[j+1] <= ax_s[j] + (ay_s[j] >>> j);
						ay_s[j+1] <= ay_s[j] - (ax_s[j] >>> j);
						az_s[j+1] <= az_s[j] + ATAN_TAB[j];
					end else begin
						ax_s[j+1] <= ax_s[j] - (ay_s[j] >>> j);
						ay_s[j+1] <= ay_s[j] + (ax_s[j] >>> j);
						az_s[j+1] <= az_s[j] - ATAN_TAB[j];
					end
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (adv) begin
					ax_s[j+1] <= ax_s[j];
					ay_s[j+1] <= ay_s[j];
					az_s[j+1] <= az_s[j];
				end
			end
		end
	end

	assign ux_w = $signed({2'b00, q0_s[DIV_STEPS]});
	assign uy_w = $signed({2'b00, q1_s[DIV_STEPS]});

	always_ff @(posedge clk) begin
		if (adv) begin
			theta_q <= az_s[DIV_STEPS][ANG_W-1] ? 26'd0 : az_s[DIV_STEPS][25:0];
			ux_q    <= 32'(n0_s[DIV_STEPS] ? -ux_w : ux_w);
			uy_q    <= 32'(n1_s[DIV_STEPS] ? -uy_w : uy_w);
			zero_q  <= zr_s[DIV_STEPS];
		end
	end

	assign out_valid = v_s[VLAT-1];
	assign theta     = theta_q;
	assign ux        = ux_q;
	assign uy        = uy_q;
	assign on_axis   = zero_q;

endmodule

`default_nettype wire

// File: hdl/fsim_scale.sv
// ----------------------------------------------------------------------------
// Fisheye sphere-to-image map: radial scale pipeline
// Image radius, equidistant offset, limit test and cubic Horner scale.
// ----------------------------------------------------------------------------
`default_nettype none

module fsim_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  fsim_pkg::cfg_t     cfg,
	input  logic               in_valid,
	input  logic [25:0]        theta,
	input  logic signed [31:0] ux,
	input  logic signed [31:0] uy,
	input  logic               on_axis,
	output logic               out_valid,
	output logic signed [31:0] x_off,
	output logic signed [31:0] y_off,
	output logic signed [32:0] scale,
	output logic               beyond
);
	import fsim_pkg::*;

	logic [4:0] v_s;

	logic [29:0]        rho_s1;
	logic signed [31:0] ux_s1, uy_s1;
	logic signed [31:0] x_s2, y_s2, x_s3, y_s3, x_s4, y_s4, x_s5, y_s5;
	logic               bl_s2, bl_s3, bl_s4, bl_s5;
	logic [29:0]        rq_s2, rq_s3, rq_s4;
	logic signed [32:0] h_s3, h_s4, sc_s5;

	logic [49:0]        rho_p;
	logic signed [62:0] xp, yp, xt, yt, xn, yn;
	logic [53:0]        rn40;
	logic signed [15:0] a1, a2, a3;
	logic signed [18:0] a0;
	logic signed [30:0] rqs3, rqs4;
	logic signed [46:0] hp1;
	logic signed [63:0] hp2, hp3;
	logic signed [63:0] t1, t2, t3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (adv)
			v_s <= {v_s[3:0], in_valid};
	end

	assign rho_p = theta * cfg.ppr;

	assign xp = $signed({1'b0, rho_s1}) * ux_s1;
	assign yp = $signed({1'b0, rho_s1}) * uy_s1;
	assign xt = xp >>> 30;
	assign yt = yp >>> 30;
	assign xn = -xt;
	assign yn = -yt;
	assign rn40 = rho_s1 * cfg.inv_norm;

	assign a1 = $signed(cfg.poly[15:0]);
	assign a2 = $signed(cfg.poly[31:16]);
	assign a3 = $signed(cfg.poly[47:32]);
	assign a0 = ONE_Q14 - 19'(a1) - 19'(a2) - 19'(a3);

	assign rqs3 = $signed({1'b0, rq_s2});
	assign hp1  = a3 * rqs3;
	assign t1   = (64'(hp1) >>> 20) + 64'(a2);

	assign rqs4 = $signed({1'b0, rq_s3});
	assign hp2  = 64'(h_s3 * rqs4);
	assign t2   = (hp2 >>> 20) + 64'(a1);

	assign hp3  = 64'(h_s4 * $signed({1'b0, rq_s4}));
	assign t3   = (hp3 >>> 20) + 64'(a0);

	always_ff @(posedge clk) begin
		if (adv) begin
			rho_s1 <= on_axis ? 30'd0 : rho_p[49:20];
			ux_s1  <= ux;
			uy_s1  <= uy;

			x_s2  <= xn[31:0];
			y_s2  <= yn[31:0];
			bl_s2 <= rn40 >= {4'd0, cfg.limit, 30'd0};
			rq_s2 <= rn40[49:20];

			x_s3  <= x_s2;
			y_s3  <= y_s2;
			bl_s3 <= bl_s2;
			rq_s3 <= rq_s2;
			h_s3  <= clamp_scale(t1);

			x_s4  <= x_s3;
			y_s4  <= y_s3;
			bl_s4 <= bl_s3;
			rq_s4 <= rq_s3;
			h_s4  <= clamp_scale(t2);

			x_s5  <= x_s4;
			y_s5  <= y_s4;
			bl_s5 <= bl_s4;
			sc_s5 <= bl_s4 ? SCALE_FAR : clamp_scale(t3);
		end
	end

	assign out_valid = v_s[4];
	assign x_off     = x_s5;
	assign y_off     = y_s5;
	assign scale     = sc_s5;
	assign beyond    = bl_s5;

endmodule

`default_nettype wire

// File: hdl/fsim_place.sv
// ----------------------------------------------------------------------------
// Fisheye sphere-to-image map: placement pipeline
// Scaled pixel position, center shift, circular crop test and frame
// normalization with output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module fsim_place (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  fsim_pkg::cfg_t     cfg,
	input  logic               in_valid,
	input  logic signed [31:0] x_off,
	input  logic signed [31:0] y_off,
	input  logic signed [32:0] scale,
	input  logic               beyond,
	output logic               out_valid,
	output logic signed [19:0] x_norm,
	output logic signed [19:0] y_norm,
	output logic               valid_res,
	output logic               beyond_limit
);
	import fsim_pkg::*;

	logic [4:0] v_s;

	logic signed [64:0] mx_s1, my_s1;
	logic               bl_s1, bl_s2, bl_s3, bl_s4;
	logic signed [39:0] px_s2, py_s2;
	logic               uo_s3, vo_s3, uo_s4, vo_s4;
	logic [19:0]        u_s3, v_s3;
	logic signed [40:0] posx_s3, posy_s3;
	logic [40:0]        uu_s4;
	logic signed [65:0] nx_s4, ny_s4;
	logic signed [19:0] xn_s5, yn_s5;
	logic               ok_s5, bl_s5;

	logic signed [64:0] tx, ty;
	logic [38:0]        ax, ay;
	logic [62:0]        ucw, vch;
	logic               outside;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (adv)
			v_s <= {v_s[3:0], in_valid};
	end

	assign tx = (mx_s1 >>> 14) + (65'($signed(cfg.shift[15:0])) <<< 12);
	assign ty = (my_s1 >>> 14) + (65'($signed(cfg.shift[31:16])) <<< 12);

	assign ax  = 39'(px_s2[39] ? -px_s2 : px_s2);
	assign ay  = 39'(py_s2[39] ? -py_s2 : py_s2);
	assign ucw = ax * cfg.crop[23:0];
	assign vch = ay * cfg.crop[47:24];

	assign outside = cfg.crop[48] & (uo_s4 | vo_s4 | (uu_s4 > 41'd274877906944));

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1 <= x_off * scale;
			my_s1 <= y_off * scale;
			bl_s1 <= beyond;

			px_s2 <= clamp_pos(tx);
			py_s2 <= clamp_pos(ty);
			bl_s2 <= bl_s1;

			uo_s3   <= ucw[62:20] > 43'd524288;
			vo_s3   <= vch[62:20] > 43'd524288;
			u_s3    <= ucw[39:20];
			v_s3    <= vch[39:20];
			posx_s3 <= 41'(px_s2) + $signed({11'd0, cfg.offset[15:0], 14'd0});
			posy_s3 <= 41'(py_s2) + $signed({11'd0, cfg.offset[31:16], 14'd0});
			bl_s3   <= bl_s2;

			uo_s4 <= uo_s3;
			vo_s4 <= vo_s3;
			uu_s4 <= 41'(u_s3 * u_s3) + 41'(v_s3 * v_s3);
			nx_s4 <= posx_s3 * $signed({1'b0, cfg.inv_size[23:0]});
			ny_s4 <= posy_s3 * $signed({1'b0, cfg.inv_size[47:24]});
			bl_s4 <= bl_s3;

			ok_s5 <= !outside;
			xn_s5 <= outside ? 20'sd0 : clamp_norm(nx_s4 >>> 24);
			yn_s5 <= outside ? 20'sd0 : clamp_norm(ny_s4 >>> 24);
			bl_s5 <= bl_s4;
		end
	end

	assign out_valid    = v_s[4];
	assign x_norm       = xn_s5;
	assign y_norm       = yn_s5;
	assign valid_res    = ok_s5;
	assign beyond_limit = bl_s5;

endmodule

`default_nettype wire

// File: hdl/fisheye_sphere_to_image_map_unit.sv
// ----------------------------------------------------------------------------
// Fisheye sphere-to-image map unit
// Maps a longitude and latitude to normalized fisheye image coordinates.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock and returns one result item for each,
// in order. The pipeline depth is set by the one-iteration-per-stage CORDIC,
// square root and divider pipelines. The whole pipeline advances together:
// while a result waits at the output, no stage moves and no item is taken.
// The user must write registers through the APB port only while the unit
// holds no items; the unit itself does not enforce this.
`default_nettype none

module fisheye_sphere_to_image_map_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // longitude [15:0], latitude [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // x_norm [19:0], y_norm [39:20]
	output logic [1:0]  m_tuser   // valid_res [0], beyond_limit [1]
);
	import fsim_pkg::*;

	cfg_t cfg;
	logic adv;

	logic               sc_valid;
	logic signed [31:0] cos_lon, sin_lon, cos_lat, sin_lat;
	logic               vec_valid;
	logic [25:0]        theta;
	logic signed [31:0] ux, uy;
	logic               on_axis;
	logic               scl_valid;
	logic signed [31:0] x_off, y_off;
	logic signed [32:0] scale;
	logic               beyond;
	logic signed [19:0] x_norm, y_norm;
	logic               valid_res, beyond_limit;

	assign adv      = !m_tvalid | m_tready;
	assign s_tready = adv;

	fsim_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fsim_sincos u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.lon       ($signed(s_tdata[15:0])),
		.lat       ($signed(s_tdata[31:16])),
		.out_valid (sc_valid),
		.cos_lon   (cos_lon),
		.sin_lon   (sin_lon),
		.cos_lat   (cos_lat),
		.sin_lat   (sin_lat)
	);

	fsim_vector u_vector (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sc_valid),
		.cos_lon   (cos_lon),
		.sin_lon   (sin_lon),
		.cos_lat   (cos_lat),
		.sin_lat   (sin_lat),
		.out_valid (vec_valid),
		.theta     (theta),
		.ux        (ux),
		.uy        (uy),
		.on_axis   (on_axis)
	);

	fsim_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.in_valid  (vec_valid),
		.theta     (theta),
		.ux        (ux),
		.uy        (uy),
		.on_axis   (on_axis),
		.out_valid (scl_valid),
		.x_off     (x_off),
		.y_off     (y_off),
		.scale     (scale),
		.beyond    (beyond)
	);

	fsim_place u_place (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.cfg          (cfg),
		.in_valid     (scl_valid),
		.x_off        (x_off),
		.y_off        (y_off),
		.scale        (scale),
		.beyond       (beyond),
		.out_valid    (m_tvalid),
		.x_norm       (x_norm),
		.y_norm       (y_norm),
		.valid_res    (valid_res),
		.beyond_limit (beyond_limit)
	);

	assign m_tdata = {y_norm, x_norm};
	assign m_tuser = {beyond_limit, valid_res};

endmodule

`default_nettype wire
